/* rtl/itar_pkg.sv */
// Shared types, constants and helper functions for the integer-to-ASCII radix converter.
// Used by every module in the rtl folder; has no dependencies of its own.
`default_nettype none

package itar_pkg;

  // Number of low bits of the input value that take part in the conversion.
  localparam int unsigned VALUE_BITS = 64;

  // Digit counts of the widest magnitude in each radix.
  localparam int unsigned OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int unsigned HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int unsigned DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

  // Octal always needs the most digits, so it sizes the digit buffer.
  localparam int unsigned BUF_DIGITS = OCT_DIGITS;
  localparam int unsigned PTR_W      = $clog2(BUF_DIGITS);
  localparam int unsigned OCT_BITS   = OCT_DIGITS * 3;
  localparam int unsigned BUF_BITS   = BUF_DIGITS * 4;

  // Binary-to-BCD conversion consumes one nibble per cycle.
  localparam int unsigned DAB_BITS  = HEX_DIGITS * 4;
  localparam int unsigned DAB_STEPS = HEX_DIGITS;
  localparam int unsigned STEP_W    = $clog2(DAB_STEPS);

  localparam logic [PTR_W-1:0]  PTR_OCT_TOP = PTR_W'(OCT_DIGITS - 1);
  localparam logic [PTR_W-1:0]  PTR_DEC_TOP = PTR_W'(DEC_DIGITS - 1);
  localparam logic [PTR_W-1:0]  PTR_HEX_TOP = PTR_W'(HEX_DIGITS - 1);
  localparam logic [STEP_W-1:0] STEP_TOP    = STEP_W'(DAB_STEPS - 1);

  localparam logic [VALUE_BITS-1:0] VALUE_ONE = VALUE_BITS'(1);

  // Job queue between the front and back parts.
  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned JQ_PTR_W  = $clog2(JOB_DEPTH);
  localparam int unsigned JQ_CNT_W  = $clog2(JOB_DEPTH + 1);
  localparam logic [JQ_PTR_W-1:0] JQ_LAST = JQ_PTR_W'(JOB_DEPTH - 1);
  localparam logic [JQ_CNT_W-1:0] JQ_FULL = JQ_CNT_W'(JOB_DEPTH);

  // ASCII characters.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Base selector codes on the input.
  localparam logic [1:0] SEL_OCT = 2'd0;
  localparam logic [1:0] SEL_DEC = 2'd1;

  typedef enum logic [1:0] {
    RADIX_OCT,
    RADIX_DEC,
    RADIX_HEX
  } radix_e;

  typedef enum logic [1:0] {
    SIGN_NONE,
    SIGN_MINUS,
    SIGN_PLUS
  } sign_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_SIGN,
    BK_PRE0,
    BK_PRE1,
    BK_DIGIT
  } back_state_e;

  typedef struct packed {
    logic [63:0] value;
    logic        signed_mode;
    logic [1:0]  base_sel;
    logic        upper_digits;
    logic        with_prefix;
    logic        plus_sign;
  } item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
  } result_t;

  // One classified number waiting for rendering.
  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;
    radix_e                radix;
    logic                  upper;
    logic                  prefix;
    sign_e                 sign;
  } job_t;

  // Maps one digit value to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'b0000, d};
    end else begin
      r = (upper ? CH_UP_A : CH_LOW_A) + {4'b0000, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/itar_front.sv */
// Front part of the converter: accepts input items and classifies them into jobs.
// Depends on itar_pkg for the item and job types.
`default_nettype none

module itar_front (
  input  wire               push_i,
  input  itar_pkg::item_t   item_i,
  output logic              full_o,
  input  wire               fifo_full_i,
  output logic              fifo_push_o,
  output itar_pkg::job_t    job_o
);

  logic [itar_pkg::VALUE_BITS-1:0] raw;
  logic                            negative;

  // Keep only the active value bits and take the magnitude, then resolve
  // radix, prefix and sign character; an unused selector means hex.
  always_comb begin
    raw      = item_i.value[itar_pkg::VALUE_BITS-1:0];
    negative = item_i.signed_mode & raw[itar_pkg::VALUE_BITS-1];
    job_o.mag = negative ? (~raw + itar_pkg::VALUE_ONE) : raw;
    case (item_i.base_sel)
      itar_pkg::SEL_OCT: job_o.radix = itar_pkg::RADIX_OCT;
      itar_pkg::SEL_DEC: job_o.radix = itar_pkg::RADIX_DEC;
      default:           job_o.radix = itar_pkg::RADIX_HEX;
    endcase
    job_o.upper  = item_i.upper_digits;
    job_o.prefix = item_i.with_prefix && (job_o.radix != itar_pkg::RADIX_DEC);
    if (negative) begin
      job_o.sign = itar_pkg::SIGN_MINUS;
    end else if (item_i.plus_sign) begin
      job_o.sign = itar_pkg::SIGN_PLUS;
    end else begin
      job_o.sign = itar_pkg::SIGN_NONE;
    end
  end

  // A transfer goes straight into the job queue.
  assign full_o      = fifo_full_i;
  assign fifo_push_o = push_i && !fifo_full_i;

endmodule

`default_nettype wire

/* rtl/itar_fifo.sv */
// Short job queue that decouples the front and back parts of the converter.
// Depends on itar_pkg for the job type and queue depth.
`default_nettype none

module itar_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  itar_pkg::job_t      wdata_i,
  input  wire                 pop_i,
  output itar_pkg::job_t      rdata_o,
  output logic                full_o,
  output logic                empty_o
);

  itar_pkg::job_t                 mem_q [itar_pkg::JOB_DEPTH];
  logic [itar_pkg::JQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [itar_pkg::JQ_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [itar_pkg::JQ_CNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == itar_pkg::JQ_FULL);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == itar_pkg::JQ_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == itar_pkg::JQ_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/itar_back.sv */
// Back part of the converter: turns one job into digits and emits characters in order.
// Depends on itar_pkg for types, digit counts and the digit_char function.
`default_nettype none

module itar_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  itar_pkg::job_t      job_i,
  input  wire                 job_empty_i,
  output logic                job_pop_o,
  input  wire                 pop_i,
  output logic                res_valid_o,
  output itar_pkg::result_t   result_o
);

  itar_pkg::back_state_e                      state_q, state_d;
  itar_pkg::job_t                             job_q, job_d;
  logic [itar_pkg::BUF_DIGITS-1:0][3:0]       dig_q, dig_d;
  logic [itar_pkg::DAB_BITS-1:0]              sh_q, sh_d;
  logic [itar_pkg::STEP_W-1:0]                step_q, step_d;
  logic [itar_pkg::PTR_W-1:0]                 ptr_q, ptr_d;
  logic                                       lead_q, lead_d;
  itar_pkg::result_t                          out_q, out_d;
  logic                                       out_valid_q, out_valid_d;

  logic                                       out_free;
  logic [3:0]                                 cur_digit;
  logic                                       skip;
  logic                                       emit;
  itar_pkg::result_t                          emit_res;
  logic [itar_pkg::OCT_BITS-1:0]              oct_src;
  logic [itar_pkg::DAB_BITS-1:0]              hex_src;
  logic [itar_pkg::BUF_DIGITS-1:0][3:0]       spread;
  logic [itar_pkg::BUF_BITS-1:0]              bcd;
  logic [3:0]                                 nib;

  assign out_free  = !out_valid_q || pop_i;
  assign cur_digit = dig_q[ptr_q];
  assign skip      = lead_q && (cur_digit == 4'd0) && (ptr_q != '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      itar_pkg::BK_IDLE: begin
        if (!job_empty_i) begin
          state_d = (job_i.radix == itar_pkg::RADIX_DEC) ? itar_pkg::BK_CONV
                                                         : itar_pkg::BK_SIGN;
        end
      end
      itar_pkg::BK_CONV: begin
        if (step_q == '0) begin
          state_d = itar_pkg::BK_SIGN;
        end
      end
      itar_pkg::BK_SIGN: begin
        if ((job_q.sign == itar_pkg::SIGN_NONE) || out_free) begin
          state_d = job_q.prefix ? itar_pkg::BK_PRE0 : itar_pkg::BK_DIGIT;
        end
      end
      itar_pkg::BK_PRE0: begin
        if (out_free) begin
          state_d = itar_pkg::BK_PRE1;
        end
      end
      itar_pkg::BK_PRE1: begin
        if (out_free) begin
          state_d = itar_pkg::BK_DIGIT;
        end
      end
      itar_pkg::BK_DIGIT: begin
        if (!skip && out_free && (ptr_q == '0)) begin
          state_d = itar_pkg::BK_IDLE;
        end
      end
      default: state_d = itar_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue pop and the character to emit.
  always_comb begin
    job_pop_o          = 1'b0;
    emit               = 1'b0;
    emit_res.char_out  = itar_pkg::CH_ZERO;
    emit_res.last_char = 1'b0;
    case (state_q)
      itar_pkg::BK_IDLE: begin
        job_pop_o = !job_empty_i;
      end
      itar_pkg::BK_SIGN: begin
        emit              = (job_q.sign != itar_pkg::SIGN_NONE) && out_free;
        emit_res.char_out = (job_q.sign == itar_pkg::SIGN_MINUS) ? itar_pkg::CH_MINUS
                                                                 : itar_pkg::CH_PLUS;
      end
      itar_pkg::BK_PRE0: begin
        emit              = out_free;
        emit_res.char_out = itar_pkg::CH_ZERO;
      end
      itar_pkg::BK_PRE1: begin
        emit              = out_free;
        emit_res.char_out = (job_q.radix == itar_pkg::RADIX_OCT) ? itar_pkg::CH_O
                                                                 : itar_pkg::CH_X;
      end
      itar_pkg::BK_DIGIT: begin
        emit               = !skip && out_free;
        emit_res.char_out  = itar_pkg::digit_char(cur_digit, job_q.upper);
        emit_res.last_char = (ptr_q == '0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Digit slots taken directly from the magnitude in octal and hex.
  always_comb begin
    oct_src = '0;
    oct_src[itar_pkg::VALUE_BITS-1:0] = job_i.mag;
    hex_src = '0;
    hex_src[itar_pkg::VALUE_BITS-1:0] = job_i.mag;
    for (int k = 0; k < itar_pkg::BUF_DIGITS; k++) begin
      if (job_i.radix == itar_pkg::RADIX_OCT) begin
        spread[k] = {1'b0, oct_src[3*k +: 3]};
      end else if (k < itar_pkg::HEX_DIGITS) begin
        spread[k] = hex_src[4*k +: 4];
      end else begin
        spread[k] = 4'd0;
      end
    end
  end

  // One nibble of shift-and-add-3 binary-to-BCD conversion per cycle.
  always_comb begin
    bcd = dig_q;
    nib = sh_q[itar_pkg::DAB_BITS-1 -: 4];
    for (int j = 3; j >= 0; j--) begin
      for (int k = 0; k < itar_pkg::BUF_DIGITS; k++) begin
        if (bcd[4*k +: 4] >= 4'd5) begin
          bcd[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
        end
      end
      bcd = {bcd[itar_pkg::BUF_BITS-2:0], nib[j]};
    end
  end

  // Datapath register updates.
  always_comb begin
    job_d       = job_q;
    dig_d       = dig_q;
    sh_d        = sh_q;
    step_d      = step_q;
    ptr_d       = ptr_q;
    lead_d      = lead_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    case (state_q)
      itar_pkg::BK_IDLE: begin
        if (!job_empty_i) begin
          job_d  = job_i;
          sh_d   = hex_src;
          step_d = itar_pkg::STEP_TOP;
          lead_d = 1'b1;
          case (job_i.radix)
            itar_pkg::RADIX_OCT: begin
              dig_d = spread;
              ptr_d = itar_pkg::PTR_OCT_TOP;
            end
            itar_pkg::RADIX_DEC: begin
              dig_d = '0;
              ptr_d = itar_pkg::PTR_DEC_TOP;
            end
            default: begin
              dig_d = spread;
              ptr_d = itar_pkg::PTR_HEX_TOP;
            end
          endcase
        end
      end
      itar_pkg::BK_CONV: begin
        dig_d  = bcd;
        sh_d   = sh_q << 4;
        step_d = step_q - 1'b1;
      end
      itar_pkg::BK_DIGIT: begin
        if (skip) begin
          ptr_d = ptr_q - 1'b1;
        end else if (out_free) begin
          lead_d = 1'b0;
          if (ptr_q != '0) begin
            ptr_d = ptr_q - 1'b1;
          end
        end
      end
      default: begin
        ptr_d = ptr_q;
      end
    endcase
    // Result register: load on emit, drain on a transfer.
    if (emit) begin
      out_d       = emit_res;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itar_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    dig_q  <= dig_d;
    sh_q   <= sh_d;
    step_q <= step_d;
    ptr_q  <= ptr_d;
    lead_q <= lead_d;
    out_q  <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

`default_nettype wire

/* rtl/integer_to_ascii_radix.sv */
// Top level of the integer-to-ASCII radix converter.
// Instantiates itar_front, itar_fifo and itar_back; depends on itar_pkg.
`default_nettype none

// Renders one 64-bit number per input transfer as ASCII text, one character
// per result transfer, most significant first: an optional '-' or '+', an
// optional "0o" or "0x" prefix, then the digits, with last_char set on the
// final digit. While the job queue is not full, the front part takes one item
// per cycle into that two-entry queue, so up to two numbers can be queued
// while one is being rendered. The back sequencer handles one number at a
// time: it loads the job, runs the nibble-wide binary-to-BCD conversion in
// decimal, passes the sign slot, then steps through the prefix characters,
// the emitted digits and the leading zeros that are skipped (the digit
// pointer always starts at the widest digit count of the radix: 22 octal,
// 20 decimal, 16 hex).
module integer_to_ascii_radix (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  input  itar_pkg::item_t     item_i,
  output logic                full,
  output logic                empty,
  input  wire                 pop,
  output itar_pkg::result_t   result_o
);

  itar_pkg::job_t push_job;
  itar_pkg::job_t pop_job;
  logic           fifo_push;
  logic           fifo_pop;
  logic           fifo_full;
  logic           fifo_empty;
  logic           res_valid;

  itar_front u_front (
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .fifo_full_i (fifo_full),
    .fifo_push_o (fifo_push),
    .job_o       (push_job)
  );

  itar_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (push_job),
    .pop_i   (fifo_pop),
    .rdata_o (pop_job),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  itar_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .job_empty_i (fifo_empty),
    .job_pop_o   (fifo_pop),
    .pop_i       (pop && res_valid),
    .res_valid_o (res_valid),
    .result_o    (result_o)
  );

  assign empty = !res_valid;

  // The back part never takes a job from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty)
    else $error("job queue popped while empty");

  // The front part never writes into a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full)
    else $error("job queue pushed while full");

  // Loading a job takes the back part out of idle, so pops never come back to back.
  a_pop_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_pop && $past(fifo_pop)) |-> 1'b0)
    else $error("two jobs popped on consecutive cycles");

endmodule

`default_nettype wire

/* sim/integer_to_ascii_radix_tb.sv */
// Self-checking testbench for integer_to_ascii_radix: a table of directed numbers, then random ones.
// Characters are predicted in the testbench and compared one transfer at a time. Needs itar_pkg.
module integer_to_ascii_radix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itar_pkg::*;

  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 45;
  localparam int CYCLE_LIMIT   = 400000;

  // The hexadecimal selector and the unused code that also means hexadecimal.
  localparam logic [1:0] SEL_HEX     = 2'd2;
  localparam logic [1:0] SEL_HEX_ALT = 2'd3;

  localparam string LOWER_DIGITS = "0123456789abcdef";
  localparam string UPPER_DIGITS = "0123456789ABCDEF";

  // One directed row: an empty text means the predictor supplies the characters.
  typedef struct {
    item_t item;
    string text;
  } number_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    push;
  item_t   item_i;
  logic    full;
  logic    empty;
  logic    pop;
  result_t result_o;

  result_t     pending_chars[$];
  number_row_t number_rows[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          mismatch_count;
  int          cycle_count;
  int          chars_seen;

  integer_to_ascii_radix DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .item_i  (item_i),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Prints one line per mismatch and counts it.
  task automatic log_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic item_t mk_item(input logic [63:0] value, input logic sgn,
                                    input logic [1:0] sel, input logic up,
                                    input logic pre, input logic plus);
    item_t it;
    it.value        = value;
    it.signed_mode  = sgn;
    it.base_sel     = sel;
    it.upper_digits = up;
    it.with_prefix  = pre;
    it.plus_sign    = plus;
    return it;
  endfunction

  // Text that the block should emit for one number: sign, prefix, then digits.
  function automatic string render_number(input item_t it);
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] mag;
    logic [63:0] radix;
    logic [3:0]  d;
    logic        negative;
    string       digits;
    string       text;
    mask     = ~64'd0 >> (64 - VALUE_BITS);
    v        = it.value & mask;
    negative = it.signed_mode && v[VALUE_BITS-1];
    mag      = negative ? ((~v + 64'd1) & mask) : v;
    case (it.base_sel)
      SEL_OCT: radix = 64'd8;
      SEL_DEC: radix = 64'd10;
      default: radix = 64'd16;
    endcase
    digits = "";
    do begin
      d = 4'(mag % radix);
      digits = $sformatf("%c%s", it.upper_digits ? UPPER_DIGITS[d] : LOWER_DIGITS[d], digits);
      mag = mag / radix;
    end while (mag != 64'd0);
    // A zero never counts as negative, so it gets a plus only when plus_sign is set.
    if (negative) begin
      text = "-";
    end else if (it.plus_sign) begin
      text = "+";
    end else begin
      text = "";
    end
    // The prefix letter is lowercase whatever the digit case; decimal has none.
    if (it.with_prefix && it.base_sel != SEL_DEC) begin
      text = $sformatf("%s%c%c", text, CH_ZERO, (it.base_sel == SEL_OCT) ? CH_O : CH_X);
    end
    return {text, digits};
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    case ($urandom_range(0, 4))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 999));
      2: v = ~64'($urandom_range(0, 999));
      3: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  // Queues the characters of one accepted number, last flag on the final one.
  task automatic queue_text(input string text);
    result_t r;
    for (int i = 0; i < text.len(); i++) begin
      r.char_out  = text[i];
      r.last_char = (i == text.len() - 1);
      pending_chars.push_back(r);
    end
  endtask

  // Sender idles at random before offering the next number.
  task automatic idle_gap();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Offers one number and returns at the edge of its transfer.
  task automatic offer(input item_t it, input string text);
    item_i <= it;
    push   <= 1'b1;
    do @(posedge clk_i); while (full);
    queue_text((text.len() != 0) ? text : render_number(it));
  endtask

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("integer_to_ascii_radix verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    bit held_once;
    held_once = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held_once) begin
        pop <= 1'b0;
        for (int held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
        held_once = 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compares each popped character with the oldest expected one.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        log_mismatch($sformatf("unexpected char 0x%02h last %0b", result_o.char_out,
                               result_o.last_char));
      end else begin
        want = pending_chars.pop_front();
        if (result_o.char_out !== want.char_out) begin
          log_mismatch($sformatf("char %0d: char_out 0x%02h, expected 0x%02h", chars_seen,
                                 result_o.char_out, want.char_out));
        end
        if (result_o.last_char !== want.last_char) begin
          log_mismatch($sformatf("char %0d: last_char %0b, expected %0b", chars_seen,
                                 result_o.last_char, want.last_char));
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    item_t it;
    rst_ni <= 1'b0;
    push   <= 1'b0;
    item_i <= '0;
    hold_req = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 70;

    // Extremes, every radix, and the corner cases of sign, prefix and selector.
    number_rows.push_back('{mk_item(64'd0, 1'b0, SEL_DEC, 1'b0, 1'b0, 1'b0), "0"});
    number_rows.push_back('{mk_item(64'd0, 1'b1, SEL_DEC, 1'b0, 1'b0, 1'b1), "+0"});
    number_rows.push_back('{mk_item(64'd0, 1'b1, SEL_HEX, 1'b0, 1'b1, 1'b0), "0x0"});
    number_rows.push_back('{mk_item(64'd0, 1'b0, SEL_OCT, 1'b0, 1'b1, 1'b0), "0o0"});
    number_rows.push_back('{mk_item(~64'd0, 1'b0, SEL_DEC, 1'b0, 1'b0, 1'b0),
                            "18446744073709551615"});
    number_rows.push_back('{mk_item(~64'd0, 1'b1, SEL_DEC, 1'b0, 1'b0, 1'b0), "-1"});
    number_rows.push_back('{mk_item(64'h8000_0000_0000_0000, 1'b1, SEL_DEC, 1'b0, 1'b0, 1'b0),
                            "-9223372036854775808"});
    number_rows.push_back('{mk_item(64'h8000_0000_0000_0000, 1'b1, SEL_HEX, 1'b1, 1'b1, 1'b0),
                            "-0x8000000000000000"});
    number_rows.push_back('{mk_item(~64'd0, 1'b0, SEL_OCT, 1'b0, 1'b1, 1'b1),
                            "+0o1777777777777777777777"});
    number_rows.push_back('{mk_item(64'h8000_0000_0000_0000, 1'b0, SEL_OCT, 1'b0, 1'b1, 1'b0),
                            "0o1000000000000000000000"});
    number_rows.push_back('{mk_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, SEL_DEC, 1'b0, 1'b1, 1'b1),
                            "+9223372036854775807"});
    number_rows.push_back('{mk_item(64'd255, 1'b0, SEL_HEX, 1'b1, 1'b1, 1'b0), "0xFF"});
    number_rows.push_back('{mk_item(64'd255, 1'b0, SEL_HEX, 1'b0, 1'b1, 1'b0), "0xff"});
    number_rows.push_back('{mk_item(64'd42, 1'b0, SEL_DEC, 1'b0, 1'b1, 1'b0), "42"});
    number_rows.push_back('{mk_item(64'hABC, 1'b0, SEL_HEX_ALT, 1'b0, 1'b0, 1'b0), "abc"});
    number_rows.push_back('{mk_item(64'd7, 1'b0, SEL_OCT, 1'b0, 1'b0, 1'b1), "+7"});
    number_rows.push_back('{mk_item(~64'd0, 1'b0, SEL_HEX, 1'b0, 1'b0, 1'b0),
                            "ffffffffffffffff"});
    number_rows.push_back('{mk_item(64'hFFFF_FFFF_FFFF_FF01, 1'b1, SEL_HEX, 1'b1, 1'b1, 1'b1),
                            "-0xFF"});
    number_rows.push_back('{mk_item(64'h0123_4567_89AB_CDEF, 1'b0, SEL_HEX, 1'b1, 1'b0, 1'b0),
                            "123456789ABCDEF"});
    number_rows.push_back('{mk_item(64'd8, 1'b0, SEL_OCT, 1'b0, 1'b0, 1'b0), "10"});
    number_rows.push_back('{mk_item(64'd10, 1'b0, SEL_DEC, 1'b0, 1'b0, 1'b0), "10"});
    number_rows.push_back('{mk_item(64'hDEAD_BEEF_CAFE_F00D, 1'b1, SEL_OCT, 1'b1, 1'b1, 1'b1), ""});
    number_rows.push_back('{mk_item(64'd12345, 1'b1, SEL_HEX, 1'b1, 1'b1, 1'b1), ""});
    number_rows.push_back('{mk_item(64'h0F0F_0000_F0F0_1234, 1'b0, SEL_HEX_ALT, 1'b1, 1'b1, 1'b1),
                            ""});

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (number_rows[i]) begin
      idle_gap();
      offer(number_rows[i].item, number_rows[i].text);
    end

    // Sender pauses until the directed numbers have fully drained.
    push <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);

    // Receiver holds off early on so the job queue fills and push is stalled.
    hold_req = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 28;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      it = mk_item(random_value(), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      idle_gap();
      offer(it, "");
    end

    push <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("integer_to_ascii_radix verification clean");
    end else begin
      $display("integer_to_ascii_radix verification failed");
    end
    $finish;
  end

endmodule
